### sv/dd_odo_pkg.sv
// shared types, constants and tables for the odometry integrator
// no dependencies; used by the controller, datapath and top level
`timescale 1ns / 1ps
`default_nettype none

package dd_odo_pkg;

    localparam int CORDIC_ITERS = 16;
    localparam int CNT_W        = 5;

    localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(CORDIC_ITERS - 1);

    localparam logic [31:0] LIN_GAIN_RST = 32'd191898783;
    localparam logic [31:0] ANG_GAIN_RST = 32'd770688920;
    localparam logic [33:0] CORDIC_START = 34'sd652032874;
    localparam logic [33:0] HEAD_SCALE   = 34'd44798134;
    localparam logic [21:0] US_PER_S     = 22'd1000000;
    localparam logic [21:0] US_PER_S2    = 22'd2000000;
    localparam logic [50:0] US_HALF      = 51'd500000;
    // floor(2^52 / 10^6), applied to the dividend with its low 20 bits dropped
    localparam logic [33:0] RECIP_US     = 34'd4503599627;

    localparam logic [7:0] REG_LIN_GAIN = 8'd0;
    localparam logic [7:0] REG_ANG_GAIN = 8'd1;

    localparam logic [4:0] OP_NONE = 5'd0;
    localparam logic [4:0] OP_LOAD = 5'd1;
    localparam logic [4:0] OP_CORD = 5'd2;
    localparam logic [4:0] OP_M0   = 5'd3;
    localparam logic [4:0] OP_M1   = 5'd4;
    localparam logic [4:0] OP_M2   = 5'd5;
    localparam logic [4:0] OP_M3   = 5'd6;
    localparam logic [4:0] OP_M4   = 5'd7;
    localparam logic [4:0] OP_M5   = 5'd8;
    localparam logic [4:0] OP_M6   = 5'd9;
    localparam logic [4:0] OP_M7   = 5'd10;
    localparam logic [4:0] OP_M8   = 5'd11;
    localparam logic [4:0] OP_HEAD = 5'd12;
    localparam logic [4:0] OP_Q0   = 5'd13;
    localparam logic [4:0] OP_Q1   = 5'd14;
    localparam logic [4:0] OP_Q2   = 5'd15;
    localparam logic [4:0] OP_Q3   = 5'd16;
    localparam logic [4:0] OP_Q4   = 5'd17;
    localparam logic [4:0] OP_Q5   = 5'd18;
    localparam logic [4:0] OP_DONE = 5'd19;

    typedef struct packed {
        logic [4:0]       op;
        logic [CNT_W-1:0] iter;
    } cmd_t;

    typedef struct packed {
        logic out_blocked;
    } status_t;

    function automatic logic [31:0] atan_bam(input logic [CNT_W-1:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/dd_odo_ctrl.sv
// sequencer for the odometry integrator: one item at a time
// depends on dd_odo_pkg
`timescale 1ns / 1ps
`default_nettype none

module dd_odo_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire dd_odo_pkg::status_t status,
    output dd_odo_pkg::cmd_t         cmd
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CORD = 5'd1;
    localparam logic [4:0] S_M0   = 5'd2;
    localparam logic [4:0] S_M1   = 5'd3;
    localparam logic [4:0] S_M2   = 5'd4;
    localparam logic [4:0] S_M3   = 5'd5;
    localparam logic [4:0] S_M4   = 5'd6;
    localparam logic [4:0] S_M5   = 5'd7;
    localparam logic [4:0] S_M6   = 5'd8;
    localparam logic [4:0] S_M7   = 5'd9;
    localparam logic [4:0] S_M8   = 5'd10;
    localparam logic [4:0] S_HEAD = 5'd11;
    localparam logic [4:0] S_Q0   = 5'd12;
    localparam logic [4:0] S_Q1   = 5'd13;
    localparam logic [4:0] S_Q2   = 5'd14;
    localparam logic [4:0] S_Q3   = 5'd15;
    localparam logic [4:0] S_Q4   = 5'd16;
    localparam logic [4:0] S_Q5   = 5'd17;
    localparam logic [4:0] S_DONE = 5'd18;

    logic [4:0]                   state_reg, state_next;
    logic [dd_odo_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = dd_odo_pkg::OP_NONE;
        cmd.iter   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = dd_odo_pkg::OP_LOAD;
                    cnt_next   = '0;
                    state_next = S_CORD;
                end
            end
            S_CORD:
            begin
                cmd.op   = dd_odo_pkg::OP_CORD;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == dd_odo_pkg::ITER_LAST)
                begin
                    state_next = S_M0;
                end
            end
            S_M0: begin cmd.op = dd_odo_pkg::OP_M0; state_next = S_M1; end
            S_M1: begin cmd.op = dd_odo_pkg::OP_M1; state_next = S_M2; end
            S_M2: begin cmd.op = dd_odo_pkg::OP_M2; state_next = S_M3; end
            S_M3: begin cmd.op = dd_odo_pkg::OP_M3; state_next = S_M4; end
            S_M4: begin cmd.op = dd_odo_pkg::OP_M4; state_next = S_M5; end
            S_M5: begin cmd.op = dd_odo_pkg::OP_M5; state_next = S_M6; end
            S_M6: begin cmd.op = dd_odo_pkg::OP_M6; state_next = S_M7; end
            S_M7: begin cmd.op = dd_odo_pkg::OP_M7; state_next = S_M8; end
            S_M8: begin cmd.op = dd_odo_pkg::OP_M8; state_next = S_HEAD; end
            S_HEAD: begin cmd.op = dd_odo_pkg::OP_HEAD; state_next = S_Q0; end
            S_Q0: begin cmd.op = dd_odo_pkg::OP_Q0; state_next = S_Q1; end
            S_Q1: begin cmd.op = dd_odo_pkg::OP_Q1; state_next = S_Q2; end
            S_Q2: begin cmd.op = dd_odo_pkg::OP_Q2; state_next = S_Q3; end
            S_Q3: begin cmd.op = dd_odo_pkg::OP_Q3; state_next = S_Q4; end
            S_Q4: begin cmd.op = dd_odo_pkg::OP_Q4; state_next = S_Q5; end
            S_Q5: begin cmd.op = dd_odo_pkg::OP_Q5; state_next = S_DONE; end
            S_DONE:
            begin
                if (!status.out_blocked)
                begin
                    cmd.op     = dd_odo_pkg::OP_DONE;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### sv/dd_odo_dp.sv
// datapath: cordic, shared multiplier, constant divider and pose registers
// depends on dd_odo_pkg
`timescale 1ns / 1ps
`default_nettype none

module dd_odo_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dd_odo_pkg::cmd_t    cmd,
    output dd_odo_pkg::status_t      status,
    input  wire logic [31:0]         lin_gain,
    input  wire logic [31:0]         ang_gain,
    input  wire logic signed [23:0]  left_speed,
    input  wire logic signed [23:0]  right_speed,
    input  wire logic [15:0]         elapsed_us,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [31:0]       pos_x,
    output logic signed [31:0]       pos_y,
    output logic [31:0]              heading,
    output logic signed [31:0]       fwd_speed,
    output logic signed [31:0]       turn_rate
);

    logic signed [24:0] sum_reg, diff_reg;
    logic [15:0]        us_reg;
    logic signed [67:0] prod_reg;
    logic signed [31:0] fwd_reg, turn_reg;
    logic signed [33:0] ax_reg, ay_reg;
    logic signed [50:0] px_reg, py_reg;
    logic signed [48:0] tu_reg;
    logic [49:0]        lo_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic               flip_reg;
    logic [50:0]        nx_reg, ny_reg;
    logic [31:0]        qx_reg, qy_reg;
    logic [21:0]        rx_reg, ry_reg;
    logic               sx_reg, sy_reg;
    logic [31:0]        acc_x_reg, acc_y_reg, acc_h_reg;
    logic               out_valid_reg;
    logic [31:0]        pos_x_reg, pos_y_reg, head_reg, fwd_out_reg, turn_out_reg;

    logic signed [33:0] op_a, op_b, cos_v, sin_v;
    logic signed [67:0] prod_w;
    logic signed [43:0] rnd24;
    logic signed [31:0] sat24;
    logic signed [33:0] rnd30;
    logic signed [32:0] z_ang, z_fold;
    logic               fold;
    logic signed [33:0] dxs, dys, atan_v;
    logic [63:0]        hsum;
    logic [50:0]        nx_w, ny_w;
    logic [31:0]        adj_x, adj_y;
    logic [31:0]        dx, dy;

    assign cos_v = flip_reg ? -x_reg : x_reg;
    assign sin_v = flip_reg ? -y_reg : y_reg;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (cmd.op)
            dd_odo_pkg::OP_M0: begin op_a = 34'(sum_reg);  op_b = {2'b00, lin_gain}; end
            dd_odo_pkg::OP_M1: begin op_a = 34'(diff_reg); op_b = {2'b00, ang_gain}; end
            dd_odo_pkg::OP_M2: begin op_a = 34'(fwd_reg);  op_b = cos_v; end
            dd_odo_pkg::OP_M3: begin op_a = 34'(fwd_reg);  op_b = sin_v; end
            dd_odo_pkg::OP_M4: begin op_a = ax_reg;        op_b = {18'd0, us_reg}; end
            dd_odo_pkg::OP_M5: begin op_a = ay_reg;        op_b = {18'd0, us_reg}; end
            dd_odo_pkg::OP_M6: begin op_a = 34'(turn_reg); op_b = {18'd0, us_reg}; end
            dd_odo_pkg::OP_M7:
            begin
                op_a = {10'd0, prod_reg[23:0]};
                op_b = dd_odo_pkg::HEAD_SCALE;
            end
            dd_odo_pkg::OP_M8:
            begin
                // upper part of turn times time keeps its sign
                op_a = 34'(signed'(tu_reg[48:24]));
                op_b = dd_odo_pkg::HEAD_SCALE;
            end
            dd_odo_pkg::OP_Q0:
            begin
                op_a = {3'd0, nx_reg[50:20]};
                op_b = dd_odo_pkg::RECIP_US;
            end
            dd_odo_pkg::OP_Q1:
            begin
                op_a = {3'd0, ny_reg[50:20]};
                op_b = dd_odo_pkg::RECIP_US;
            end
            dd_odo_pkg::OP_Q2: begin op_a = {2'd0, qx_reg}; op_b = {12'd0, dd_odo_pkg::US_PER_S}; end
            dd_odo_pkg::OP_Q3: begin op_a = {2'd0, qy_reg}; op_b = {12'd0, dd_odo_pkg::US_PER_S}; end
            default: ;
        endcase
    end

    assign prod_w = op_a * op_b;

    // round half up then saturate to 32 bits
    assign rnd24 = 44'((prod_reg + 68'sd8388608) >>> 24);
    assign sat24 = (rnd24[43:31] == {13{rnd24[43]}}) ? rnd24[31:0]
                 : (rnd24[43] ? 32'sh80000000 : 32'sh7fffffff);
    assign rnd30 = 34'((prod_reg + 68'sd536870912) >>> 30);

    // fold heading into the right half plane
    assign z_ang  = 33'(signed'(acc_h_reg));
    assign fold   = (z_ang > 33'sh040000000) || (z_ang < -33'sh040000000);
    assign z_fold = (z_ang > 33'sh040000000) ? z_ang - 33'sh080000000
                  : (z_ang < -33'sh040000000) ? z_ang + 33'sh080000000 : z_ang;

    assign dxs    = y_reg >>> cmd.iter;
    assign dys    = x_reg >>> cmd.iter;
    assign atan_v = {2'b00, dd_odo_pkg::atan_bam(cmd.iter)};

    assign hsum = {prod_reg[39:0], 24'd0} + {14'd0, lo_reg} + 64'h80000000;

    assign nx_w = (px_reg[50] ? 51'(-px_reg) : 51'(px_reg)) + dd_odo_pkg::US_HALF;
    assign ny_w = (py_reg[50] ? 51'(-py_reg) : 51'(py_reg)) + dd_odo_pkg::US_HALF;

    // divide by 10^6: the reciprocal estimate is low by at most two,
    // so the back-multiplied remainder stays below 3 * 10^6
    assign adj_x = (rx_reg >= dd_odo_pkg::US_PER_S2) ? 32'd2
                 : (rx_reg >= dd_odo_pkg::US_PER_S) ? 32'd1 : 32'd0;
    assign adj_y = (ry_reg >= dd_odo_pkg::US_PER_S2) ? 32'd2
                 : (ry_reg >= dd_odo_pkg::US_PER_S) ? 32'd1 : 32'd0;

    assign dx = sx_reg ? -qx_reg : qx_reg;
    assign dy = sy_reg ? -qy_reg : qy_reg;

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            dd_odo_pkg::OP_LOAD:
            begin
                sum_reg  <= 25'(left_speed) + 25'(right_speed);
                diff_reg <= 25'(right_speed) - 25'(left_speed);
                us_reg   <= elapsed_us;
                x_reg    <= dd_odo_pkg::CORDIC_START;
                y_reg    <= '0;
                z_reg    <= 34'(z_fold);
                flip_reg <= fold;
            end
            dd_odo_pkg::OP_CORD:
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - dxs;
                    y_reg <= y_reg + dys;
                    z_reg <= z_reg - atan_v;
                end
                else
                begin
                    x_reg <= x_reg + dxs;
                    y_reg <= y_reg - dys;
                    z_reg <= z_reg + atan_v;
                end
            end
            dd_odo_pkg::OP_M0: prod_reg <= prod_w;
            dd_odo_pkg::OP_M1: begin fwd_reg  <= sat24; prod_reg <= prod_w; end
            dd_odo_pkg::OP_M2: begin turn_reg <= sat24; prod_reg <= prod_w; end
            dd_odo_pkg::OP_M3: begin ax_reg <= rnd30; prod_reg <= prod_w; end
            dd_odo_pkg::OP_M4: begin ay_reg <= rnd30; prod_reg <= prod_w; end
            dd_odo_pkg::OP_M5: begin px_reg <= prod_reg[50:0]; prod_reg <= prod_w; end
            dd_odo_pkg::OP_M6: begin py_reg <= prod_reg[50:0]; prod_reg <= prod_w; end
            dd_odo_pkg::OP_M7: begin tu_reg <= prod_reg[48:0]; prod_reg <= prod_w; end
            dd_odo_pkg::OP_M8: begin lo_reg <= prod_reg[49:0]; prod_reg <= prod_w; end
            dd_odo_pkg::OP_HEAD:
            begin
                sx_reg <= px_reg[50];
                sy_reg <= py_reg[50];
                nx_reg <= nx_w;
                ny_reg <= ny_w;
            end
            dd_odo_pkg::OP_Q0: prod_reg <= prod_w;
            dd_odo_pkg::OP_Q1: begin qx_reg <= prod_reg[63:32]; prod_reg <= prod_w; end
            dd_odo_pkg::OP_Q2: begin qy_reg <= prod_reg[63:32]; prod_reg <= prod_w; end
            dd_odo_pkg::OP_Q3:
            begin
                rx_reg   <= 22'(nx_reg - prod_reg[50:0]);
                prod_reg <= prod_w;
            end
            dd_odo_pkg::OP_Q4:
            begin
                ry_reg <= 22'(ny_reg - prod_reg[50:0]);
                qx_reg <= qx_reg + adj_x;
            end
            dd_odo_pkg::OP_Q5: qy_reg <= qy_reg + adj_y;
            dd_odo_pkg::OP_DONE:
            begin
                pos_x_reg    <= acc_x_reg + dx;
                pos_y_reg    <= acc_y_reg + dy;
                head_reg     <= acc_h_reg;
                fwd_out_reg  <= fwd_reg;
                turn_out_reg <= turn_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_h_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == dd_odo_pkg::OP_HEAD)
            begin
                acc_h_reg <= acc_h_reg + hsum[63:32];
            end
            if (cmd.op == dd_odo_pkg::OP_DONE)
            begin
                acc_x_reg     <= acc_x_reg + dx;
                acc_y_reg     <= acc_y_reg + dy;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_blocked = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign heading   = head_reg;
    assign fwd_speed = fwd_out_reg;
    assign turn_rate = turn_out_reg;

endmodule

`default_nettype wire

### sv/diff_drive_odometry_integrator.sv
// top level of the differential drive odometry integrator
// depends on dd_odo_pkg, dd_odo_ctrl and dd_odo_dp
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake            payload
// in       sink       in_valid / in_stall  left_speed, right_speed, elapsed_us
// out      source     out_valid/out_stall  pos_x, pos_y, heading, fwd_speed, turn_rate
// cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item passes through load, cordic, multiply, heading, divide and output steps:
// the cordic rotates once a cycle, one shared multiplier runs nine products
// in sequence, and the rounded divide by 10^6 is a reciprocal multiply,
// a back multiply and a small correction on the same multiplier
// reset clears the pose to zero and loads the default gains
// in_stall is high from acceptance until the result is loaded into the
// output register; a stalled output holds the block in its final step only

module diff_drive_odometry_integrator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [23:0] left_speed,
    input  wire logic signed [23:0] right_speed,
    input  wire logic [15:0]        elapsed_us,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic [31:0]             heading,
    output logic signed [31:0]      fwd_speed,
    output logic signed [31:0]      turn_rate,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    dd_odo_pkg::cmd_t    cmd;
    dd_odo_pkg::status_t status;

    logic [31:0] lin_gain_reg, ang_gain_reg;

    // config writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_gain_reg <= dd_odo_pkg::LIN_GAIN_RST;
            ang_gain_reg <= dd_odo_pkg::ANG_GAIN_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == dd_odo_pkg::REG_LIN_GAIN)
            begin
                lin_gain_reg <= cfg_data;
            end
            else if (cfg_index == dd_odo_pkg::REG_ANG_GAIN)
            begin
                ang_gain_reg <= cfg_data;
            end
        end
    end

    // sequencer
    dd_odo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and pose state
    dd_odo_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .lin_gain    (lin_gain_reg),
        .ang_gain    (ang_gain_reg),
        .left_speed  (left_speed),
        .right_speed (right_speed),
        .elapsed_us  (elapsed_us),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .heading     (heading),
        .fwd_speed   (fwd_speed),
        .turn_rate   (turn_rate)
    );

endmodule

`default_nettype wire

### sv/dd_odo_checker.sv
// port-level checks for the odometry integrator, bound to the top level
// depends on diff_drive_odometry_integrator
`timescale 1ns / 1ps
`default_nettype none

module dd_odo_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] pos_x,
    input wire logic        cfg_ready
);

    // a held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pos_x))
        else $error("output changed while stalled");

    // an accepted item makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    // the cordic alone keeps the block busy for many cycles
    a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##16 in_stall)
        else $error("item finished too early");

    // config port never back-pressures
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");

endmodule

bind diff_drive_odometry_integrator dd_odo_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pos_x     (pos_x),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
